// File: sv/nll_pkg.sv
// nll_pkg: constants and fixed-point formats of the nonlinear ladder lowpass
// shared by the ladder top level; no dependencies
`default_nettype none

package nll_pkg;

  // shaper format: magnitudes in Q.24
  localparam int TQ = 24;
  localparam int TV_W = 29;
  localparam int TR_W = 25;
  localparam logic [TR_W-1:0] ONE = TR_W'(1) << TQ;
  localparam logic [TV_W-1:0] TH_LIMIT = TV_W'(3) << TQ;
  localparam logic [TV_W-1:0] TH_BIAS = TV_W'(27) << TQ;

  // tanh datapath widths
  localparam int MAG_W = 26;
  localparam int S_W = 28;
  localparam int NA_W = 30;
  localparam int NUM_W = 56;
  localparam int DEN_W = 31;
  localparam int QUO_W = 28;
  localparam int DCNT_W = 5;

  // shared multiplier narrow operand
  localparam int MB_W = 26;

  // feedback gain fraction bits, ladder gain fraction bits
  localparam int KQ = 13;
  localparam int GQ = 16;

  // configuration port
  localparam int CFG_W = 16;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_LADDER_GAIN = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK_GAIN = 1'd1;
  localparam logic [CFG_W-1:0] LADDER_GAIN_RESET = 16'd3569;
  localparam logic [CFG_W-1:0] FEEDBACK_GAIN_RESET = 16'd4096;

endpackage

`default_nettype wire

// File: sv/nll_if.sv
// nll_if: valid/ready stream interfaces for the ladder sample and result words
// no dependencies; used by nonlinear_ladder_lowpass_top
`default_nettype none

interface nll_in_if #(
  parameter int W = 16
);
  logic valid;
  logic ready;
  logic signed [W-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink (input valid, input sample_in, output ready);
endinterface

interface nll_out_if #(
  parameter int W = 16
);
  logic valid;
  logic ready;
  logic signed [W-1:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink (input valid, input sample_out, output ready);
endinterface

`default_nettype wire

// File: sv/nonlinear_ladder_lowpass_top.sv
// nonlinear_ladder_lowpass_top: four-pole ladder lowpass with tanh shapers
// depends on nll_pkg and the stream interfaces in nll_if
// One sample word is taken while the block is idle and one filtered word comes
// out for it. Every shaper pass runs on one shared multiplier and a 28-step
// restoring divider, so a new sample is taken only once the last one is filtered.
// The feedback shaper skips the divider when its input is at or beyond
// 3.0. The input and output shapers never see an input that large. The result
// sits in an output register, so the next sample is taken while the previous
// word still waits. The new result is held back until that word is taken.
// ladder_gain and feedback_gain are written through the plain write port while
// idle; the user must keep to this, as the block does not enforce it. The four stage values reset to zero.
`default_nettype none

module nonlinear_ladder_lowpass_top
  import nll_pkg::*;
#(
  parameter int SAMPLE_WIDTH = 16,
  parameter int STATE_WIDTH = 24
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_write,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  nll_in_if.sink                    sample_stream,
  nll_out_if.source                 result_stream
);

  localparam int SQ = STATE_WIDTH - 1;
  localparam int XQ = SAMPLE_WIDTH - 1;
  localparam int SH_UP = (SQ >= TQ) ? SQ - TQ : 0;
  localparam int SH_DN = (SQ >= TQ) ? 0 : TQ - SQ;
  localparam int RS_W = (STATE_WIDTH > TR_W) ? STATE_WIDTH : TR_W;
  localparam int MA_W = (STATE_WIDTH > NA_W) ? STATE_WIDTH : NA_W;
  localparam int P_W = MA_W + MB_W;
  localparam int FB_SH = KQ + SQ - TQ;
  localparam logic [STATE_WIDTH-1:0] ST_FULL = STATE_WIDTH'(1) << SQ;
  localparam logic [SAMPLE_WIDTH-1:0] SMP_FULL = SAMPLE_WIDTH'(1) << XQ;

  typedef enum logic [3:0] {
    S_IDLE,
    S_TH_START,
    S_TH_SQ,
    S_TH_NUM,
    S_TH_DLOAD,
    S_TH_DIV,
    S_TH_DONE,
    S_FB_MUL,
    S_FB_SUB,
    S_STG_MUL,
    S_STG_ADD,
    S_OUT_PREP,
    S_OUT
  } state_t;

  typedef enum logic [1:0] {
    PH_IN,
    PH_FB,
    PH_OUT
  } phase_t;

  state_t state;
  phase_t phase;

  logic [CFG_W-1:0] ladder_gain;
  logic [CFG_W-1:0] feedback_gain;
  logic signed [STATE_WIDTH-1:0] stage [4];

  logic signed [TV_W-1:0] tv;
  logic signed [TV_W-1:0] x;
  logic signed [STATE_WIDTH-1:0] src;
  logic neg;
  logic dneg;
  logic [MAG_W-1:0] mag;
  logic [P_W-1:0] prod;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den;
  logic [QUO_W-1:0] dlow;
  logic [QUO_W-1:0] quo;
  logic [DCNT_W-1:0] div_count;
  logic [1:0] stage_count;
  logic out_valid;
  logic signed [SAMPLE_WIDTH-1:0] y;

  // combinational datapath
  logic [TV_W-1:0] tv_abs;
  logic th_sat;
  logic [S_W-1:0] s_val;
  logic [NA_W-1:0] num_a;
  logic [DEN_W-1:0] den_next;
  logic [NUM_W-1:0] num;
  logic [DEN_W:0] trial;
  logic div_ge;
  logic [DEN_W-1:0] rem_next;
  logic [TR_W-1:0] th_mag;
  logic [RS_W-1:0] th_wide;
  logic [STATE_WIDTH-1:0] drive_mag;
  logic signed [STATE_WIDTH-1:0] drive_val;
  logic [SAMPLE_WIDTH-1:0] smp_mag;
  logic signed [SAMPLE_WIDTH-1:0] smp_val;
  logic [STATE_WIDTH-1:0] st3_abs;
  logic [RS_W-1:0] st3_wide;
  logic [TV_W-1:0] st3_tv;
  logic [TV_W-1:0] fb_mag;
  logic signed [TV_W-1:0] fb_val;
  logic signed [STATE_WIDTH:0] diff;
  logic [STATE_WIDTH:0] diff_abs;
  logic [STATE_WIDTH-1:0] inc_mag;
  logic signed [STATE_WIDTH-1:0] stage_new;
  logic [MA_W-1:0] mul_a;
  logic [MB_W-1:0] mul_b;
  logic [P_W-1:0] prod_next;

  always_comb begin
    tv_abs = tv[TV_W-1] ? TV_W'(-tv) : TV_W'(tv);
    th_sat = tv_abs >= TH_LIMIT;

    s_val = prod[TQ +: S_W];
    num_a = NA_W'(TH_BIAS) + NA_W'(s_val);
    den_next = DEN_W'(TH_BIAS) + DEN_W'({s_val, 3'b000}) + DEN_W'(s_val);
    num = prod[NUM_W-1:0];

    trial = {rem, dlow[QUO_W-1]};
    div_ge = trial >= {1'b0, den};
    rem_next = div_ge ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];

    th_mag = (quo > QUO_W'(ONE)) ? ONE : quo[TR_W-1:0];

    th_wide = (RS_W'(th_mag) << SH_UP) >> SH_DN;
    drive_mag = th_wide[STATE_WIDTH-1:0];
    if (neg) begin
      drive_val = STATE_WIDTH'(-drive_mag);
    end else if (drive_mag == ST_FULL) begin
      drive_val = STATE_WIDTH'(ST_FULL - STATE_WIDTH'(1));
    end else begin
      drive_val = drive_mag;
    end

    smp_mag = SAMPLE_WIDTH'(th_mag >> (TQ - XQ));
    if (neg) begin
      smp_val = SAMPLE_WIDTH'(-smp_mag);
    end else if (smp_mag == SMP_FULL) begin
      smp_val = SAMPLE_WIDTH'(SMP_FULL - SAMPLE_WIDTH'(1));
    end else begin
      smp_val = smp_mag;
    end

    st3_abs = stage[3][STATE_WIDTH-1] ? STATE_WIDTH'(-stage[3]) : STATE_WIDTH'(stage[3]);
    st3_wide = (RS_W'(st3_abs) << SH_DN) >> SH_UP;
    st3_tv = TV_W'(st3_wide[TR_W-1:0]);

    fb_mag = TV_W'(prod[FB_SH +: S_W]);
    fb_val = stage[3][STATE_WIDTH-1] ? TV_W'(-fb_mag) : TV_W'(fb_mag);

    diff = (STATE_WIDTH + 1)'(src) - (STATE_WIDTH + 1)'(stage[0]);
    diff_abs = diff[STATE_WIDTH] ? (STATE_WIDTH + 1)'(-diff) : (STATE_WIDTH + 1)'(diff);
    inc_mag = prod[GQ +: STATE_WIDTH];
    stage_new = dneg ? STATE_WIDTH'(stage[0] - inc_mag) : STATE_WIDTH'(stage[0] + inc_mag);

    case (state)
      S_TH_SQ: begin
        mul_a = MA_W'(mag);
        mul_b = MB_W'(mag);
      end
      S_TH_NUM: begin
        mul_a = MA_W'(num_a);
        mul_b = MB_W'(mag);
      end
      S_FB_MUL: begin
        mul_a = MA_W'(st3_abs);
        mul_b = MB_W'(feedback_gain);
      end
      S_STG_MUL: begin
        mul_a = MA_W'(diff_abs[STATE_WIDTH-1:0]);
        mul_b = MB_W'(ladder_gain);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod_next = P_W'(mul_a) * P_W'(mul_b);
  end

  assign sample_stream.ready = (state == S_IDLE);
  assign result_stream.valid = out_valid;
  assign result_stream.sample_out = y;

  always_ff @(posedge clk) begin
    prod <= prod_next;

    if (rst) begin
      state <= S_IDLE;
      phase <= PH_IN;
      out_valid <= 1'b0;
      ladder_gain <= LADDER_GAIN_RESET;
      feedback_gain <= FEEDBACK_GAIN_RESET;
      for (int i = 0; i < 4; i++) begin
        stage[i] <= '0;
      end
      div_count <= '0;
      stage_count <= '0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_LADDER_GAIN:   ladder_gain <= cfg_data;
          REG_FEEDBACK_GAIN: feedback_gain <= cfg_data;
          default: ;
        endcase
      end

      if (state == S_OUT && (!out_valid || result_stream.ready)) begin
        out_valid <= 1'b1;
      end else if (result_stream.ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (sample_stream.valid) begin
            tv <= TV_W'(sample_stream.sample_in) <<< (TQ - XQ);
            phase <= PH_IN;
            state <= S_TH_START;
          end
        end
        S_TH_START: begin
          neg <= tv[TV_W-1];
          mag <= tv_abs[MAG_W-1:0];
          if (th_sat) begin
            quo <= QUO_W'(ONE);
            state <= S_TH_DONE;
          end else begin
            state <= S_TH_SQ;
          end
        end
        S_TH_SQ: begin
          state <= S_TH_NUM;
        end
        S_TH_NUM: begin
          den <= den_next;
          state <= S_TH_DLOAD;
        end
        S_TH_DLOAD: begin
          rem <= DEN_W'(num[NUM_W-1:QUO_W]);
          dlow <= num[QUO_W-1:0];
          div_count <= '0;
          state <= S_TH_DIV;
        end
        S_TH_DIV: begin
          rem <= rem_next;
          dlow <= {dlow[QUO_W-2:0], 1'b0};
          quo <= {quo[QUO_W-2:0], div_ge};
          div_count <= div_count + DCNT_W'(1);
          if (div_count == DCNT_W'(QUO_W - 1)) begin
            state <= S_TH_DONE;
          end
        end
        S_TH_DONE: begin
          case (phase)
            PH_IN: begin
              x <= neg ? -TV_W'(th_mag) : TV_W'(th_mag);
              state <= S_FB_MUL;
            end
            PH_FB: begin
              src <= drive_val;
              stage_count <= '0;
              state <= S_STG_MUL;
            end
            default: begin
              state <= S_OUT;
            end
          endcase
        end
        S_FB_MUL: begin
          state <= S_FB_SUB;
        end
        S_FB_SUB: begin
          tv <= x - fb_val;
          phase <= PH_FB;
          state <= S_TH_START;
        end
        S_STG_MUL: begin
          dneg <= diff[STATE_WIDTH];
          state <= S_STG_ADD;
        end
        S_STG_ADD: begin
          // rotate the stages so the next one sits at the head
          stage[0] <= stage[1];
          stage[1] <= stage[2];
          stage[2] <= stage[3];
          stage[3] <= stage_new;
          src <= stage_new;
          stage_count <= stage_count + 2'd1;
          state <= (stage_count == 2'd3) ? S_OUT_PREP : S_STG_MUL;
        end
        S_OUT_PREP: begin
          tv <= stage[3][STATE_WIDTH-1] ? TV_W'(-st3_tv) : st3_tv;
          phase <= PH_OUT;
          state <= S_TH_START;
        end
        S_OUT: begin
          if (!out_valid || result_stream.ready) begin
            y <= smp_val;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: verif/tb_nonlinear_ladder_lowpass_top.sv
// tb_nonlinear_ladder_lowpass_top: self-checking bench for the four-pole tanh ladder lowpass
// predicts every filtered word with a bit-exact fixed-point ladder and compares in order
// depends on nll_pkg, nll_in_if/nll_out_if and nonlinear_ladder_lowpass_top
`timescale 1ns / 100ps

module tb_nonlinear_ladder_lowpass_top;
  import nll_pkg::*;

  localparam int SAMPLE_W = 16;
  localparam int STATE_W = 24;
  localparam int SAMPLE_Q = SAMPLE_W - 1;
  localparam int STATE_Q = STATE_W - 1;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int DRAIN_CYCLES = 150;
  localparam int RANDOM_ITEMS = 2000;
  localparam int PHASES = 8;
  localparam int MAX_REPORTS = 10;

  typedef enum int {WAVE_NOISE, WAVE_SQUARE, WAVE_RAMP, WAVE_QUIET} wave_kind_t;

  logic clk;
  logic rst;
  logic cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  nll_in_if #(.W(SAMPLE_W)) sample_stream ();
  nll_out_if #(.W(SAMPLE_W)) result_stream ();

  nonlinear_ladder_lowpass_top #(
    .SAMPLE_WIDTH(SAMPLE_W),
    .STATE_WIDTH(STATE_W)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .sample_stream(sample_stream),
    .result_stream(result_stream)
  );

  logic [CFG_W-1:0] model_gain;
  logic [CFG_W-1:0] model_feedback;
  logic signed [STATE_W-1:0] model_stage [4];
  logic signed [SAMPLE_W-1:0] expected_filtered [$];
  int mismatch_count = 0;
  int cycle_count = 0;
  bit tx_gaps_on;
  bit rx_stalls_on;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // shift the magnitude (positive sh: right), truncating toward zero
  function automatic longint trunc_shift(longint v, int sh);
    longint unsigned m;
    m = (v < 0) ? -v : v;
    if (sh >= 0) m = m >> sh;
    else m = m << (-sh);
    return (v < 0) ? -longint'(m) : longint'(m);
  endfunction

  // odd rational tanh in Q.24
  function automatic longint tanh_q24(longint v);
    longint unsigned a, s, r, one;
    one = 64'd1 << TQ;
    a = (v < 0) ? -v : v;
    if (a >= 3 * one) begin
      r = one;
    end else begin
      s = (a * a) >> TQ;
      r = (a * (27 * one + s)) / (27 * one + 9 * s);
      if (r > one) r = one;
    end
    return (v < 0) ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint clamp_q(longint v, int frac);
    longint hi, lo;
    hi = (longint'(1) << frac) - 1;
    lo = -(longint'(1) << frac);
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] ladder_predict(
    logic signed [SAMPLE_W-1:0] sample
  );
    longint x, fb, drive, src, d, y;
    int i;
    x = tanh_q24(trunc_shift(longint'(sample), SAMPLE_Q - TQ));
    fb = trunc_shift(longint'(model_feedback) * longint'(model_stage[3]), KQ + STATE_Q - TQ);
    x = tanh_q24(x - fb);
    drive = clamp_q(trunc_shift(x, TQ - STATE_Q), STATE_Q);
    for (i = 0; i < 4; i++) begin
      src = (i == 0) ? drive : longint'(model_stage[i-1]);
      d = (src - longint'(model_stage[i])) * longint'(model_gain);
      model_stage[i] = STATE_W'(longint'(model_stage[i]) + trunc_shift(d, GQ));
    end
    y = tanh_q24(trunc_shift(longint'(model_stage[3]), STATE_Q - TQ));
    y = clamp_q(trunc_shift(y, TQ - SAMPLE_Q), SAMPLE_Q);
    return SAMPLE_W'(y);
  endfunction

  task automatic send_sample(input logic signed [SAMPLE_W-1:0] value);
    int gap;
    gap = tx_gaps_on ? $urandom_range(0, 3) : 0;
    repeat (gap) begin
      @(negedge clk);
      sample_stream.valid <= 1'b0;
    end
    @(negedge clk);
    sample_stream.valid <= 1'b1;
    sample_stream.sample_in <= value;
    do @(posedge clk); while (!sample_stream.ready);
    expected_filtered.push_back(ladder_predict(value));
  endtask

  task automatic wait_for_outputs();
    @(negedge clk);
    sample_stream.valid <= 1'b0;
    while (expected_filtered.size() != 0) @(posedge clk);
  endtask

  task automatic write_registers(input logic [CFG_W-1:0] gain, input logic [CFG_W-1:0] feedback);
    wait_for_outputs();
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= REG_LADDER_GAIN;
    cfg_data <= gain;
    @(negedge clk);
    cfg_index <= REG_FEEDBACK_GAIN;
    cfg_data <= feedback;
    @(negedge clk);
    cfg_write <= 1'b0;
    model_gain = gain;
    model_feedback = feedback;
  endtask

  // full-scale extremes and bit patterns at the reset gains
  task automatic test_reset_settings();
    logic signed [SAMPLE_W-1:0] pattern [7] = '{16'sh7FFF, 16'sh8000, 16'sh0000, 16'sh0001,
                                                 16'shFFFF, 16'sh5555, 16'shAAAA};
    foreach (pattern[n]) send_sample(pattern[n]);
  endtask

  // strongest feedback drives the second shaper to +1.0 and -1.0
  task automatic test_feedback_saturation();
    logic signed [SAMPLE_W-1:0] pattern [8] = '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh8000,
                                                 16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF};
    write_registers(16'hFFFF, 16'hFFFF);
    foreach (pattern[n]) send_sample(pattern[n]);
  endtask

  task automatic test_register_extremes();
    write_registers(16'd0, 16'd34406);
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    send_sample(16'sh1234);
    write_registers(16'd1, 16'd0);
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    send_sample(16'shC001);
    write_registers(16'hFFFF, 16'd0);
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    send_sample(16'sh0F0F);
  endtask

  // bursts of noise, square waves, ramps and near-silence over several gain settings
  task automatic test_random_streams();
    int phase, sent, len, period, j;
    wave_kind_t kind;
    logic signed [SAMPLE_W-1:0] value, amp, step;
    logic [CFG_W-1:0] gain, feedback;
    for (phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin
          gain = 16'hFFFF;
          feedback = 16'd34406;
        end
        1: begin
          gain = LADDER_GAIN_RESET;
          feedback = FEEDBACK_GAIN_RESET;
        end
        2: begin
          gain = CFG_W'($urandom_range(0, 65535));
          feedback = 16'hFFFF;
        end
        3: begin
          gain = CFG_W'($urandom_range(1, 2048));
          feedback = CFG_W'($urandom_range(30000, 34406));
        end
        default: begin
          gain = CFG_W'($urandom_range(0, 65535));
          feedback = CFG_W'($urandom_range(0, 65535));
        end
      endcase
      write_registers(gain, feedback);
      tx_gaps_on = (phase % 4) < 2;
      rx_stalls_on = (phase % 2) == 0;
      sent = 0;
      while (sent < RANDOM_ITEMS / PHASES) begin
        kind = wave_kind_t'($urandom_range(0, 3));
        len = $urandom_range(8, 48);
        period = $urandom_range(1, 16);
        amp = $urandom_range(0, 1) ? 16'sh7FFF : SAMPLE_W'($urandom_range(0, 32767));
        step = SAMPLE_W'($urandom_range(1, 4096));
        value = SAMPLE_W'($urandom);
        for (j = 0; j < len; j++) begin
          case (kind)
            WAVE_NOISE: value = SAMPLE_W'($urandom);
            WAVE_SQUARE: value = ((j / period) % 2) ? ~amp : amp;
            WAVE_RAMP: value = value + step;
            default: value = SAMPLE_W'(int'($urandom_range(0, 127)) - 64);
          endcase
          send_sample(value);
        end
        sent += len;
      end
    end
  endtask

  initial begin : result_sink
    int stall;
    logic signed [SAMPLE_W-1:0] want;
    result_stream.ready = 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      stall = rx_stalls_on ? $urandom_range(0, 3) : 0;
      repeat (stall) begin
        @(negedge clk);
        result_stream.ready <= 1'b0;
      end
      @(negedge clk);
      result_stream.ready <= 1'b1;
      do @(posedge clk); while (!result_stream.valid);
      if (expected_filtered.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected word: sample_out %0d", result_stream.sample_out);
      end else begin
        want = expected_filtered.pop_front();
        if (result_stream.sample_out !== want) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("sample_out mismatch: expected %0d, got %0d", want,
                     result_stream.sample_out);
        end
      end
    end
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = REG_LADDER_GAIN;
    cfg_data = '0;
    sample_stream.valid = 1'b0;
    sample_stream.sample_in = '0;
    model_gain = LADDER_GAIN_RESET;
    model_feedback = FEEDBACK_GAIN_RESET;
    foreach (model_stage[n]) model_stage[n] = '0;
    tx_gaps_on = 1'b1;
    rx_stalls_on = 1'b1;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_settings();
    test_feedback_saturation();
    test_register_extremes();
    test_random_streams();

    wait_for_outputs();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_filtered.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
